FILE: hdl/bounded_hash_memo_table_macros.svh
// Assertion shorthands for the checker of this block.
`ifndef BOUNDED_HASH_MEMO_TABLE_MACROS_SVH
`define BOUNDED_HASH_MEMO_TABLE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BHM_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BHM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/bhm_pkg.sv
package bhm_pkg;

  localparam int LOG2_SLOTS = 16;
  localparam int SLOT_W     = LOG2_SLOTS;
  localparam int SLOT_COUNT = 1 << LOG2_SLOTS;
  localparam int CNT_W      = LOG2_SLOTS + 1;
  localparam int LOAD_LIMIT = SLOT_COUNT * 3 / 4;

  localparam int KEY_W  = 63;
  localparam int VAL_W  = 64;
  localparam int RVAL_W = 32;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_LARGE   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [RVAL_W-1:0] read_value;
    logic [1:0]        status;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } hash_res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RESP
  } fsm_state_t;

endpackage

FILE: hdl/bhm_ram.sv
module bhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bhm_hash.sv
module bhm_hash
  import bhm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output hash_res_t        res
);

  // Four stages: two rounds of (three 32x32 partial products, then sum and xor-shift).
  logic [63:0] x0;
  logic [63:0] ll1_nxt, ll1_r;
  logic [31:0] lh1_nxt, lh1_r, hl1_nxt, hl1_r;
  logic [63:0] y1, x1_nxt, x1_r;
  logic [63:0] ll2_nxt, ll2_r;
  logic [31:0] lh2_nxt, lh2_r, hl2_nxt, hl2_r;
  logic [63:0] y2, h_full;
  logic [SLOT_W-1:0] slot_nxt, slot_r;
  logic [3:0] vld_r;

  assign x0 = {1'b0, key} ^ ({1'b0, key} >> 30);

  // low 64 bits of x * C: only the low halves of the cross terms matter
  assign ll1_nxt = x0[31:0] * MIX_C1[31:0];
  assign lh1_nxt = x0[31:0] * MIX_C1[63:32];
  assign hl1_nxt = x0[63:32] * MIX_C1[31:0];

  assign y1     = ll1_r + {lh1_r + hl1_r, 32'b0};
  assign x1_nxt = y1 ^ (y1 >> 27);

  assign ll2_nxt = x1_r[31:0] * MIX_C2[31:0];
  assign lh2_nxt = x1_r[31:0] * MIX_C2[63:32];
  assign hl2_nxt = x1_r[63:32] * MIX_C2[31:0];

  assign y2       = ll2_r + {lh2_r + hl2_r, 32'b0};
  assign h_full   = y2 ^ (y2 >> 31);
  assign slot_nxt = h_full[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    ll1_r  <= ll1_nxt;
    lh1_r  <= lh1_nxt;
    hl1_r  <= hl1_nxt;
    x1_r   <= x1_nxt;
    ll2_r  <= ll2_nxt;
    lh2_r  <= lh2_nxt;
    hl2_r  <= hl2_nxt;
    slot_r <= slot_nxt;
  end

  assign res.valid = vld_r[3];
  assign res.slot  = slot_r;

endmodule

FILE: hdl/bounded_hash_memo_table.sv
// Open-addressed memo table with linear probing over 2^LOG2_SLOTS slots (keys
// held as key+1, zero = empty). After reset the key memory is swept to zero,
// one slot per cycle, over all 2^LOG2_SLOTS slots (65536 at the default size);
// in_ready stays low during the sweep. Items are handled one at a time.
// An item settled by its value, load or key check goes from the input
// straight to a result register and then into the output register. Any other
// item passes the mix-hash pipeline, then probes at least one slot, one slot per
// cycle through the single read port of the key memory, then goes into the
// output register. Refused and skipped inserts are reported only through
// status.
module bounded_hash_memo_table
  import bhm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  fsm_state_t state_r, state_nxt;
  in_t        item_r, item_nxt;
  out_t       res_r, res_nxt;
  out_t       out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] probe_cnt_r, probe_cnt_nxt;
  logic [SLOT_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              in_fire;
  logic              hash_start;
  hash_res_t         hash_res;
  logic [SLOT_W-1:0] rd_addr;
  logic              key_we;
  logic [SLOT_W-1:0] key_waddr;
  logic [KEY_W-1:0]  key_wdata;
  logic [KEY_W-1:0]  key_rdata;
  logic              val_we;
  logic [RVAL_W-1:0] val_rdata;
  logic [KEY_W-1:0]  tag;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign tag       = item_r.key + KEY_W'(1);

  bhm_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_data.key),
    .res   (hash_res)
  );

  bhm_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_COUNT)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  bhm_ram #(.WIDTH(RVAL_W), .DEPTH(SLOT_COUNT)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_r),
    .wdata (item_r.value[RVAL_W-1:0]),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  // read ahead one slot per cycle; the data for slot_r arrives in PROBE
  assign rd_addr = (state_r == S_HASH) ? hash_res.slot : slot_r + SLOT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    slot_nxt      = slot_r;
    probe_cnt_nxt = probe_cnt_r;
    clr_addr_nxt  = clr_addr_r;
    count_nxt     = count_r;
    hash_start    = 1'b0;
    key_we        = 1'b0;
    key_waddr     = slot_r;
    key_wdata     = tag;
    val_we        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        key_we       = 1'b1;
        key_waddr    = clr_addr_r;
        key_wdata    = '0;
        clr_addr_nxt = clr_addr_r + SLOT_W'(1);
        if (clr_addr_r == {SLOT_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          res_nxt  = '{hit: 1'b0, read_value: '0, status: ST_OK};
          if (in_data.opcode == OP_INSERT && in_data.value[VAL_W-1:RVAL_W] != '0) begin
            res_nxt.status = ST_LARGE;
            state_nxt      = S_RESP;
          end else if (in_data.opcode == OP_INSERT && count_r >= CNT_W'(LOAD_LIMIT)) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_RESP;
          end else if (in_data.key == {KEY_W{1'b1}}) begin
            // key+1 cannot be held: lookups miss, inserts are dropped
            if (in_data.opcode == OP_INSERT) begin
              res_nxt.status = ST_FULL;
            end
            state_nxt = S_RESP;
          end else begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_res.valid) begin
          slot_nxt      = hash_res.slot;
          probe_cnt_nxt = '0;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        if (key_rdata == tag) begin
          if (item_r.opcode == OP_INSERT) begin
            res_nxt.status = ST_PRESENT;
          end else begin
            res_nxt.hit        = 1'b1;
            res_nxt.read_value = val_rdata;
          end
          state_nxt = S_RESP;
        end else if (key_rdata == '0) begin
          if (item_r.opcode == OP_INSERT) begin
            key_we    = 1'b1;
            val_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = S_RESP;
        end else if (probe_cnt_r == {SLOT_W{1'b1}}) begin
          // one full pass without a match or an empty slot
          if (item_r.opcode == OP_INSERT) begin
            res_nxt.status = ST_FULL;
          end
          state_nxt = S_RESP;
        end else begin
          slot_nxt      = slot_r + SLOT_W'(1);
          probe_cnt_nxt = probe_cnt_r + SLOT_W'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      clr_addr_r  <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
    slot_r      <= slot_nxt;
    probe_cnt_r <= probe_cnt_nxt;
  end

endmodule

FILE: hdl/bhm_checker.sv
`include "bounded_hash_memo_table_macros.svh"

module bhm_checker
  import bhm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `BHM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")
  `BHM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data), "out_data changed while stalled")
  `BHM_ASSERT_SAME(a_hit_ok, clk, rst_n, out_valid && out_data.hit, out_data.status == ST_OK, "hit with nonzero status")
  `BHM_ASSERT_SAME(a_miss_zero, clk, rst_n, out_valid && !out_data.hit, out_data.read_value == '0, "read_value nonzero without hit")
  `BHM_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "second transfer in before result")

endmodule

bind bounded_hash_memo_table bhm_checker u_bhm_checker (.*);
